// ----- src/wfg_pkg.sv -----
// ----------------------------------------------------------------------------
// wfg_pkg
// Types and codes shared by the watchdog feed gate modules.
// ----------------------------------------------------------------------------
package wfg_pkg;

  typedef enum logic [1:0] {
    KIND_HEALTH  = 2'd0,
    KIND_ENABLE  = 2'd1,
    KIND_DISABLE = 2'd2,
    KIND_PANIC   = 2'd3
  } wfg_kind_t;

  typedef enum logic [3:0] {
    RSN_NONE         = 4'd0,
    RSN_NOT_ENABLED  = 4'd1,
    RSN_PANIC        = 4'd2,
    RSN_GRACE        = 4'd3,
    RSN_HEARTBEAT    = 4'd4,
    RSN_VOLTAGE      = 4'd5,
    RSN_CURRENT      = 4'd6,
    RSN_TEMP         = 4'd7,
    RSN_HARD_FAULT   = 4'd8,
    RSN_STOP_TEST    = 4'd9,
    RSN_START_FAILED = 4'd10
  } wfg_reason_t;

  typedef enum logic [1:0] {
    CFG_GRACE_PERIOD = 2'd0,
    CFG_BOOT_TIME    = 2'd1,
    CFG_FEED_INHIBIT = 2'd2
  } wfg_cfg_idx_t;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef struct packed {
    wfg_kind_t   kind;
    logic [31:0] now_tick;
    logic [3:0]  severe_faults;
    logic        heartbeat_fault;
    logic [31:0] stale_mask;
    logic [2:0]  voltage_flags;
    logic [2:0]  current_flags;
    logic [2:0]  temp_flags;
    logic        start_ok;
  } wfg_in_t;

  typedef struct packed {
    logic        feed_pulse;
    wfg_reason_t block_reason;
    logic [31:0] feed_total;
    logic [31:0] block_total;
    logic [31:0] last_feed_time;
    logic        log_event;
    logic [31:0] log_mask;
    logic        runtime_on;
    logic        hw_running;
    logic        panicked;
  } wfg_out_t;

  typedef struct packed {
    logic [31:0] grace_period;
    logic [31:0] boot_time;
    logic        feed_inhibit;
  } wfg_cfg_t;

  typedef struct packed {
    logic        enable_gate;
    logic        started;
    logic        panic_latch;
    logic [31:0] feed_cnt;
    logic [31:0] block_cnt;
    wfg_reason_t last_logged;
    wfg_reason_t last_reason;
    logic [31:0] feed_time;
  } wfg_state_t;

  // valid bit clear, or either fault bit set
  function automatic logic flags_bad(input logic [2:0] f);
    return !f[0] || (f[2:1] != 2'b00);
  endfunction

endpackage

// ----- src/wfg_decide.sv -----
// ----------------------------------------------------------------------------
// wfg_decide
// Per-beat decision: control kinds, reason priority, start/feed, counters and log flag.
// ----------------------------------------------------------------------------
module wfg_decide
  import wfg_pkg::*;
(
  input  wfg_in_t    item,
  input  wfg_cfg_t   cfg,
  input  wfg_state_t st,
  output wfg_state_t st_nxt,
  output wfg_out_t   res
);

  wfg_reason_t rsn;
  logic        feed;
  logic        logev;
  logic [31:0] logmask;
  logic        in_grace;

  assign in_grace = (item.now_tick - cfg.boot_time) < cfg.grace_period;

  always_comb begin
    st_nxt  = st;
    rsn     = RSN_NONE;
    feed    = 1'b0;
    logev   = 1'b0;
    logmask = '0;
    unique case (item.kind)
      KIND_ENABLE: begin
        st_nxt.enable_gate = 1'b1;
        if (item.start_ok) begin
          st_nxt.started = 1'b1;
        end
      end
      KIND_DISABLE: begin
        if (!st.started) begin
          st_nxt.enable_gate = 1'b0;
        end
      end
      KIND_PANIC: begin
        st_nxt.panic_latch = 1'b1;
      end
      KIND_HEALTH: begin
        if (!st.enable_gate)                         rsn = RSN_NOT_ENABLED;
        else if (st.panic_latch)                     rsn = RSN_PANIC;
        else if (cfg.feed_inhibit)                   rsn = RSN_STOP_TEST;
        else if (in_grace)                           rsn = RSN_GRACE;
        else if (item.severe_faults != 4'd0)         rsn = RSN_HARD_FAULT;
        else if (item.heartbeat_fault || (item.stale_mask != 32'd0))
                                                     rsn = RSN_HEARTBEAT;
        else if (flags_bad(item.voltage_flags))      rsn = RSN_VOLTAGE;
        else if (flags_bad(item.current_flags))      rsn = RSN_CURRENT;
        else if (flags_bad(item.temp_flags))         rsn = RSN_TEMP;

        if (rsn == RSN_NONE || rsn == RSN_GRACE) begin
          if (st.started || item.start_ok) begin
            st_nxt.started = 1'b1;
            feed = 1'b1;
            if (st.feed_cnt != '1) begin
              st_nxt.feed_cnt = st.feed_cnt + 32'd1;
            end
            st_nxt.feed_time = item.now_tick;
          end else begin
            rsn = RSN_START_FAILED;
          end
        end
        st_nxt.last_reason = rsn;
        if (!feed && rsn != RSN_NOT_ENABLED && rsn != RSN_GRACE) begin
          if (st.block_cnt != '1) begin
            st_nxt.block_cnt = st.block_cnt + 32'd1;
          end
          if (st.last_logged != rsn) begin
            st_nxt.last_logged = rsn;
            logev   = 1'b1;
            logmask = item.stale_mask;
          end
        end
      end
    endcase
  end

  always_comb begin
    res.feed_pulse     = feed;
    res.block_reason   = st_nxt.last_reason;
    res.feed_total     = st_nxt.feed_cnt;
    res.block_total    = st_nxt.block_cnt;
    res.last_feed_time = st_nxt.feed_time;
    res.log_event      = logev;
    res.log_mask       = logmask;
    res.runtime_on     = st_nxt.enable_gate;
    res.hw_running     = st_nxt.started;
    res.panicked       = st_nxt.panic_latch;
  end

endmodule

// ----- src/watchdog_feed_gate.sv -----
// ----------------------------------------------------------------------------
// watchdog_feed_gate
// Decides per beat whether the hardware watchdog is kicked.
//
//   port group  dir  handshake           payload
//   in_*        in   in_valid/in_stall   wfg_in_t
//   out_*       out  out_valid/out_stall wfg_out_t
//   cfg_*       in   cfg_we              cfg_index, cfg_wdata
//
// One beat per cycle sustained while out_stall is low; a taken beat waits in
// the input register, then moves into the result register, which drives out_*.
// The decision logic sits between the input register and the result
// register and updates the supervisor state as the beat moves across.
// Reset clears all state and configuration. A stall on the result side
// holds the input register, then stalls the input once that is full.
// ----------------------------------------------------------------------------
module watchdog_feed_gate
  import wfg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wfg_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wfg_out_t            out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic       s1_valid_r;
  wfg_in_t    s1_data_r;
  logic       out_valid_r;
  wfg_out_t   out_data_r;
  wfg_state_t st_r;
  wfg_state_t st_nxt;
  wfg_cfg_t   cfg_r;
  wfg_out_t   res;
  logic       advance;
  logic       in_take;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  wfg_decide u_decide (
    .item   (s1_data_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      cfg_r       <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRACE_PERIOD: cfg_r.grace_period <= cfg_wdata;
          CFG_BOOT_TIME:    cfg_r.boot_time    <= cfg_wdata;
          CFG_FEED_INHIBIT: cfg_r.feed_inhibit <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.started |=> st_r.started)
    else $error("watchdog start flag dropped");

  a_log_real_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.log_event) |->
      (out_data.block_reason != RSN_NONE && out_data.block_reason != RSN_GRACE &&
       out_data.block_reason != RSN_NOT_ENABLED && !out_data.feed_pulse))
    else $error("log event without a real block reason");

  a_feed_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.feed_pulse) |-> out_data.hw_running)
    else $error("feed while watchdog not running");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room downstream");

endmodule
